// ===== hw/rtl/prc_pkg.sv =====
// Shared types and constants of the point region classifier.
// Used by prc_cell and point_region_classifier_unit; depends on nothing else.
package prc_pkg;

  localparam int COORD_W = 32;
  localparam int TAG_W   = 8;
  localparam int COUNT_W = 5;
  localparam int INDEX_W = 4;

  // Triangle sequencer timing, in cycles after the start of the run.
  localparam int TRI_STEPS = 12;
  localparam int TRI_LAST  = 17;
  localparam int TRI_CNT_W = 5;

  typedef enum logic {
    ACT_LOAD     = 1'b0,
    ACT_CLASSIFY = 1'b1
  } action_t;

  typedef enum logic {
    CFG_DIMENSION_MODE = 1'b0,
    CFG_BOUNDARY_COUNT = 1'b1
  } cfg_index_t;

  typedef enum logic [1:0] {
    CELL_IDLE,
    CELL_HOLD,
    CELL_TRI,
    CELL_SEND
  } cell_state_t;

  // One boundary entry as it is broadcast to the row on a load word.
  typedef struct packed {
    logic                      we;
    logic [INDEX_W-1:0]        index;
    logic [TAG_W-1:0]          tag;
    logic signed [COORD_W-1:0] ax;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] az;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bz;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
  } load_t;

  // The point as it travels along the row, with the result built so far.
  typedef struct packed {
    logic signed [COORD_W-1:0] px;
    logic signed [COORD_W-1:0] py;
    logic signed [COORD_W-1:0] pz;
    logic [TAG_W-1:0]          region;
    logic                      zone;
    logic                      done;
  } token_t;

endpackage

// ===== hw/rtl/prc_cell.sv =====
// One cell of the classifier row: holds one boundary entry and tests the passing point.
// Depends on prc_pkg for the entry, token and state types.
module prc_cell #(
  parameter int CELL_IDX      = 0,
  parameter int BOX_TAG_LIMIT = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          mode,
  input  logic [prc_pkg::COUNT_W-1:0]   count,
  input  prc_pkg::load_t                load,
  input  logic                          up_valid,
  input  prc_pkg::token_t               up_tok,
  output logic                          up_ready,
  output logic                          dn_valid,
  output prc_pkg::token_t               dn_tok,
  input  logic                          dn_ready,
  output logic                          busy
);

  prc_pkg::cell_state_t state_r, state_nxt;
  prc_pkg::token_t      tok_r;
  logic [prc_pkg::TAG_W-1:0]          tag_r;
  logic signed [prc_pkg::COORD_W-1:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r, cx_r, cy_r;
  logic [prc_pkg::TRI_CNT_W-1:0]      t_r;

  logic signed [31:0] m_sel, y1_sel, y2_sel;
  logic signed [31:0] a_op_r;
  logic signed [32:0] d_op_r;
  logic signed [64:0] prod_r;
  logic signed [66:0] acc_r;
  logic [65:0]        mag_r;
  logic [65:0]        whole_r;
  logic [67:0]        sum_r;
  logic [33:0]        rnd_whole_r;
  logic [35:0]        rnd_sum_r;
  logic               tri_hit_r;

  logic active, is_box, box_hit, zone_hit, need_tri;
  prc_pkg::token_t hold_tok;

  assign active = int'(count) > CELL_IDX;
  assign is_box = int'(tag_r) < BOX_TAG_LIMIT;

  assign box_hit = tok_r.px >= ax_r && tok_r.px <= bx_r && tok_r.py >= ay_r
                   && tok_r.py <= by_r
                   && (!mode || (tok_r.pz >= az_r && tok_r.pz <= bz_r));
  assign zone_hit = tok_r.px > ax_r && tok_r.px < bx_r && tok_r.py > ay_r
                    && tok_r.py < by_r;

  assign need_tri = active && !tok_r.done && !mode && !is_box;

  // Entry storage, written by a load word addressed to this slot.
  always_ff @(posedge clk) begin
    if (load.we && int'(load.index) == CELL_IDX) begin
      tag_r <= load.tag;
      ax_r  <= load.ax;
      ay_r  <= load.ay;
      az_r  <= load.az;
      bx_r  <= load.bx;
      by_r  <= load.by;
      bz_r  <= load.bz;
      cx_r  <= load.cx;
      cy_r  <= load.cy;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      prc_pkg::CELL_IDLE: begin
        if (up_valid) state_nxt = prc_pkg::CELL_HOLD;
      end
      prc_pkg::CELL_HOLD: begin
        if (need_tri) state_nxt = prc_pkg::CELL_TRI;
        else if (dn_ready) state_nxt = prc_pkg::CELL_IDLE;
      end
      prc_pkg::CELL_TRI: begin
        if (int'(t_r) == prc_pkg::TRI_LAST) state_nxt = prc_pkg::CELL_SEND;
      end
      prc_pkg::CELL_SEND: begin
        if (dn_ready) state_nxt = prc_pkg::CELL_IDLE;
      end
      default: state_nxt = prc_pkg::CELL_IDLE;
    endcase
  end

  // Result of the box rules for a point held in this cell.
  always_comb begin
    hold_tok = tok_r;
    if (active && !tok_r.done && is_box) begin
      if (!mode && CELL_IDX == 0) begin
        hold_tok.zone = zone_hit;
      end else if (box_hit) begin
        hold_tok.region = tag_r;
        hold_tok.done   = 1'b1;
      end
    end
  end

  always_comb begin
    up_ready = 1'b0;
    dn_valid = 1'b0;
    dn_tok   = tok_r;
    busy     = 1'b1;
    case (state_r)
      prc_pkg::CELL_IDLE: begin
        up_ready = 1'b1;
        busy     = 1'b0;
      end
      prc_pkg::CELL_HOLD: begin
        dn_valid = !need_tri;
        dn_tok   = hold_tok;
      end
      prc_pkg::CELL_TRI: begin
        dn_valid = 1'b0;
      end
      prc_pkg::CELL_SEND: begin
        dn_valid = 1'b1;
        if (tri_hit_r) begin
          dn_tok.region = tag_r;
          dn_tok.done   = 1'b1;
        end
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= prc_pkg::CELL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == prc_pkg::CELL_IDLE && up_valid) tok_r <= up_tok;
  end

  // Twice-area terms X.x*(Y.y-Z.y) for ABC, PBC, APC and ABP in turn.
  always_comb begin
    m_sel  = '0;
    y1_sel = '0;
    y2_sel = '0;
    case (t_r)
      5'd0:  begin m_sel = ax_r;     y1_sel = by_r;     y2_sel = cy_r;     end
      5'd1:  begin m_sel = bx_r;     y1_sel = cy_r;     y2_sel = ay_r;     end
      5'd2:  begin m_sel = cx_r;     y1_sel = ay_r;     y2_sel = by_r;     end
      5'd3:  begin m_sel = tok_r.px; y1_sel = by_r;     y2_sel = cy_r;     end
      5'd4:  begin m_sel = bx_r;     y1_sel = cy_r;     y2_sel = tok_r.py; end
      5'd5:  begin m_sel = cx_r;     y1_sel = tok_r.py; y2_sel = by_r;     end
      5'd6:  begin m_sel = ax_r;     y1_sel = tok_r.py; y2_sel = cy_r;     end
      5'd7:  begin m_sel = tok_r.px; y1_sel = cy_r;     y2_sel = ay_r;     end
      5'd8:  begin m_sel = cx_r;     y1_sel = ay_r;     y2_sel = tok_r.py; end
      5'd9:  begin m_sel = ax_r;     y1_sel = by_r;     y2_sel = tok_r.py; end
      5'd10: begin m_sel = bx_r;     y1_sel = tok_r.py; y2_sel = ay_r;     end
      5'd11: begin m_sel = tok_r.px; y1_sel = ay_r;     y2_sel = by_r;     end
      default: begin
        m_sel  = '0;
        y1_sel = '0;
        y2_sel = '0;
      end
    endcase
  end

  // Datapath: operands, product, per-area sum, magnitude, total, rounding, compare.
  always_ff @(posedge clk) begin
    if (state_r == prc_pkg::CELL_TRI) begin
      t_r    <= t_r + 1'b1;
      a_op_r <= m_sel;
      d_op_r <= {y1_sel[31], y1_sel} - {y2_sel[31], y2_sel};
      prod_r <= a_op_r * d_op_r;
      if (t_r == 5'd2 || t_r == 5'd5 || t_r == 5'd8 || t_r == 5'd11) begin
        acc_r <= 67'(prod_r);
      end else begin
        acc_r <= acc_r + 67'(prod_r);
      end
      if (t_r == 5'd5 || t_r == 5'd8 || t_r == 5'd11 || t_r == 5'd14) begin
        mag_r <= acc_r[66] ? 66'(-acc_r) : 66'(acc_r);
      end
      if (t_r == 5'd6) whole_r <= mag_r;
      if (t_r == 5'd9) sum_r <= 68'(mag_r);
      if (t_r == 5'd12 || t_r == 5'd15) sum_r <= sum_r + 68'(mag_r);
      if (t_r == 5'd16) begin
        rnd_whole_r <= 34'((67'(whole_r) + (67'd1 << 32)) >> 33);
        rnd_sum_r   <= 36'((69'(sum_r) + (69'd1 << 32)) >> 33);
      end
      if (int'(t_r) == prc_pkg::TRI_LAST) tri_hit_r <= 36'(rnd_whole_r) == rnd_sum_r;
    end else begin
      t_r <= '0;
    end
  end

  property p_tri_bounded;
    @(posedge clk) disable iff (!rst_n)
      state_r == prc_pkg::CELL_TRI |-> int'(t_r) <= prc_pkg::TRI_LAST;
  endproperty
  a_tri_bounded: assert property (p_tri_bounded) else $error("triangle counter overran");

  property p_send_after_tri;
    @(posedge clk) disable iff (!rst_n)
      $rose(state_r == prc_pkg::CELL_SEND) |-> $past(state_r) == prc_pkg::CELL_TRI;
  endproperty
  a_send_after_tri: assert property (p_send_after_tri) else $error("send without triangle run");

  property p_handoff;
    @(posedge clk) disable iff (!rst_n)
      dn_valid && dn_ready |=> state_r == prc_pkg::CELL_IDLE;
  endproperty
  a_handoff: assert property (p_handoff) else $error("cell kept a word it handed on");

endmodule

// ===== hw/rtl/point_region_classifier_unit.sv =====
// Top level of the point region classifier: a row of prc_cell, one per table entry,
// and the output register. Depends on prc_pkg and prc_cell.
//
// Usage: the input channel (in_valid/in_ready) carries load words (in_action = 0),
// which write the entry in_entry_index and give no result, and classify
// words (in_action = 1), which give one result word on out_valid/out_ready.
// A classify word walks the row of MAX_ENTRIES cells, one cell per cycle when no cell holds it.
// A cell holding a triangle that must be tested keeps the word while its one multiplier
// works through twelve area terms; box entries, skipped entries and entries after the
// first match pass it straight on. One word is in the row at a time: a new word is
// taken only once the row is empty. The result sits in an output register; a new
// word is taken while it waits, and a stalled receiver holds the last cell, and then
// the row, until out_ready.
// Configuration (cfg_we, cfg_index, cfg_wdata) is to be written by the user only while
// the row is empty; the block does not enforce this.
// Reset clears the mode and count to zero and empties the row and output register;
// entries hold no value until loaded.
module point_region_classifier_unit #(
  parameter int MAX_ENTRIES   = 16,
  parameter int BOX_TAG_LIMIT = 10
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [4:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_action,
  input  logic [3:0]          in_entry_index,
  input  logic [7:0]          in_region_tag,
  input  logic signed [31:0]  in_ax,
  input  logic signed [31:0]  in_ay,
  input  logic signed [31:0]  in_az,
  input  logic signed [31:0]  in_bx,
  input  logic signed [31:0]  in_by,
  input  logic signed [31:0]  in_bz,
  input  logic signed [31:0]  in_cx,
  input  logic signed [31:0]  in_cy,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_region,
  output logic                out_in_zone
);

  logic                                mode_r;
  logic [prc_pkg::COUNT_W-1:0]         count_r;
  logic                                out_valid_r;
  logic [prc_pkg::TAG_W-1:0]           out_region_r;
  logic                                out_zone_r;

  prc_pkg::load_t  load;
  prc_pkg::token_t head_tok;
  logic            in_accept;

  logic            valid_v [MAX_ENTRIES+1];
  logic            ready_v [MAX_ENTRIES+1];
  prc_pkg::token_t tok_v   [MAX_ENTRIES+1];
  logic [MAX_ENTRIES-1:0] busy_v;

  assign in_ready  = !(|busy_v);
  assign in_accept = in_valid && in_ready;

  assign load.we    = in_accept && in_action == prc_pkg::ACT_LOAD;
  assign load.index = in_entry_index;
  assign load.tag   = in_region_tag;
  assign load.ax    = in_ax;
  assign load.ay    = in_ay;
  assign load.az    = in_az;
  assign load.bx    = in_bx;
  assign load.by    = in_by;
  assign load.bz    = in_bz;
  assign load.cx    = in_cx;
  assign load.cy    = in_cy;

  assign head_tok.px     = in_ax;
  assign head_tok.py     = in_ay;
  assign head_tok.pz     = in_az;
  assign head_tok.region = '0;
  assign head_tok.zone   = 1'b0;
  assign head_tok.done   = 1'b0;

  assign valid_v[0] = in_accept && in_action == prc_pkg::ACT_CLASSIFY;
  assign tok_v[0]   = head_tok;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    prc_cell #(
      .CELL_IDX      (i),
      .BOX_TAG_LIMIT (BOX_TAG_LIMIT)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .mode     (mode_r),
      .count    (count_r),
      .load     (load),
      .up_valid (valid_v[i]),
      .up_tok   (tok_v[i]),
      .up_ready (ready_v[i]),
      .dn_valid (valid_v[i+1]),
      .dn_tok   (tok_v[i+1]),
      .dn_ready (ready_v[i+1]),
      .busy     (busy_v[i])
    );
  end

  assign ready_v[MAX_ENTRIES] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b0;
      count_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        prc_pkg::CFG_DIMENSION_MODE: mode_r  <= cfg_wdata[0];
        prc_pkg::CFG_BOUNDARY_COUNT: count_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (valid_v[MAX_ENTRIES] && ready_v[MAX_ENTRIES]) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (valid_v[MAX_ENTRIES] && ready_v[MAX_ENTRIES]) begin
      out_region_r <= tok_v[MAX_ENTRIES].region;
      out_zone_r   <= tok_v[MAX_ENTRIES].zone;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_region  = out_region_r;
  assign out_in_zone = out_zone_r;

  // Only one classify word is ever in the row.
  property p_single_word;
    @(posedge clk) disable iff (!rst_n) $onehot0(busy_v);
  endproperty
  a_single_word: assert property (p_single_word) else $error("two words in the row");

endmodule
